// ===== rtl/cfa_pkg.sv =====
// Shared types and constants for the contiguous frame allocator.
// Holds field widths, command and frame-state codes, and the controller/datapath structs.
// No dependencies.
package cfa_pkg;

    localparam int FRAME_W        = 20;
    localparam int COUNT_W        = 15;
    localparam int CMD_W          = 2;
    localparam int STATUS_W       = 2;
    localparam int FSTATE_W       = 2;
    localparam int TDATA_W        = 40;
    localparam int OUT_PAD_W      = TDATA_W - STATUS_W - FRAME_W - COUNT_W;
    localparam int CFG_IDX_W      = 1;
    localparam int NUM_FRAMES_DEF = 16384;
    localparam int POOL_SIZE_RST  = 16384;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd2;

    localparam logic [FSTATE_W-1:0] FS_FREE = 2'd0;
    localparam logic [FSTATE_W-1:0] FS_USED = 2'd1;
    localparam logic [FSTATE_W-1:0] FS_HEAD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_NO_FIT,
        ST_RANGE,
        ST_BAD_STATE
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_SCAN,
        S_WALK,
        S_MARK,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic    clear_step;
        logic    load;
        logic    decode;
        logic    start;
        logic    scan;
        logic    walk;
        logic    mark;
        logic    finish;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic pool_wr;
        logic clr_last;
        logic pre_ok;
        logic is_release;
        logic hit;
        logic fail;
        logic scan_end;
        logic walk_stop;
        logic mark_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/cfa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module cfa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/cfa_datapath.sv =====
// Datapath of the frame allocator: config registers, frame-state map, scan/walk/mark
// pointers, free counter and the result register. Depends on cfa_pkg and cfa_ram.
module cfa_datapath
    import cfa_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FRAME_W-1:0]   cfg_data,
    input  logic [CMD_W-1:0]     command,
    input  logic [FRAME_W-1:0]   frame_number,
    input  logic [COUNT_W-1:0]   count,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [FRAME_W-1:0]   result_frame,
    output logic [COUNT_W-1:0]   free_frames
);

    localparam int IDX_W    = $clog2(NUM_FRAMES);
    localparam int CNT_W    = $clog2(NUM_FRAMES + 1);
    localparam int LEN_W    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int SIZE_RST = (POOL_SIZE_RST > NUM_FRAMES) ? NUM_FRAMES : POOL_SIZE_RST;

    // config and bookkeeping state
    logic [LEN_W-1:0]    size_reg, size_next;
    logic [FRAME_W-1:0]  base_reg, base_next;
    logic [COUNT_W-1:0]  free_reg, free_next;
    logic [IDX_W-1:0]    clr_ptr_reg, clr_ptr_next;
    logic                chk_valid_reg, chk_valid_next;
    logic                out_valid_reg, out_valid_next;

    // captured item and work registers
    logic [CMD_W-1:0]    op_reg, op_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]    idx_reg, idx_next;
    logic                in_pool_reg, in_pool_next;
    logic [LEN_W-1:0]    rd_addr_reg, rd_addr_next;
    logic [LEN_W-1:0]    lim_reg, lim_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                first_reg, first_next;
    logic [COUNT_W-1:0]  run_reg, run_next;
    logic [IDX_W-1:0]    start_reg, start_next;
    logic [IDX_W-1:0]    mark_ptr_reg, mark_ptr_next;
    logic [COUNT_W-1:0]  mark_left_reg, mark_left_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [FRAME_W-1:0]  out_frame_reg, out_frame_next;
    logic [COUNT_W-1:0]  out_free_reg, out_free_next;

    logic                base_wr, pool_wr;
    logic [LEN_W-1:0]    cfg_pool, cfg_size;
    logic [FRAME_W:0]    diff;
    logic                in_pool_d;
    logic [LEN_W:0]      res_end;
    logic                pre_ok;
    logic                issue_valid;
    logic [FSTATE_W-1:0] fs_rd;
    logic                is_free;
    logic                is_release;
    logic                hit, fail, walk_free, walk_stop, scan_end;
    logic [IDX_W-1:0]    start_eff;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [FSTATE_W-1:0] wr_data;

    assign base_wr  = cfg_valid && (cfg_index == CFG_BASE_FRAME);
    assign pool_wr  = cfg_valid && (cfg_index == CFG_POOL_SIZE);
    assign cfg_pool = LEN_W'(cfg_data[COUNT_W-1:0]);
    assign cfg_size = (cfg_pool > LEN_W'(NUM_FRAMES)) ? LEN_W'(NUM_FRAMES) : cfg_pool;

    // pool-relative index of the requested frame
    assign diff      = {1'b0, frame_reg} - {1'b0, base_reg};
    assign in_pool_d = !diff[FRAME_W] && (diff[FRAME_W-1:0] < FRAME_W'(size_reg));
    assign res_end   = {1'b0, idx_reg} + (LEN_W + 1)'(count_reg);

    always_comb
    begin
        unique case (op_reg)
            CMD_ALLOC:   pre_ok = (count_reg != '0) && (LEN_W'(count_reg) <= size_reg);
            CMD_RELEASE: pre_ok = in_pool_reg;
            CMD_RESERVE: pre_ok = (count_reg != '0) && in_pool_reg
                                  && (res_end <= {1'b0, size_reg});
            default:     pre_ok = 1'b0;
        endcase
    end

    // scan / walk check stage works on the read data of the previous cycle
    assign issue_valid = rd_addr_reg < lim_reg;
    assign is_free     = fs_rd == FS_FREE;
    assign is_release  = op_reg == CMD_RELEASE;
    assign hit       = chk_valid_reg && !is_release && is_free
                       && (COUNT_W'(run_reg + 1'b1) == count_reg);
    assign fail      = chk_valid_reg && (is_release ? (first_reg && fs_rd != FS_HEAD)
                                                    : (op_reg == CMD_RESERVE && !is_free));
    assign walk_free = cmd.walk && chk_valid_reg
                       && (first_reg ? (fs_rd == FS_HEAD) : (fs_rd == FS_USED));
    assign walk_stop = chk_valid_reg && !first_reg && (fs_rd != FS_USED);
    assign scan_end  = !chk_valid_reg && !issue_valid;
    assign start_eff = (run_reg == '0) ? chk_idx_reg : start_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_ptr_reg;
        wr_data = FS_FREE;
        priority if (cmd.clear_step)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.mark)
        begin
            wr_en   = 1'b1;
            wr_addr = mark_ptr_reg;
            wr_data = (mark_ptr_reg == start_reg) ? FS_HEAD : FS_USED;
        end
        else if (walk_free)
        begin
            wr_en   = 1'b1;
            wr_addr = chk_idx_reg;
        end
    end

    cfa_ram #(
        .WIDTH (FSTATE_W),
        .DEPTH (NUM_FRAMES)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr_reg[IDX_W-1:0]),
        .rd_data (fs_rd)
    );

    always_comb
    begin
        size_next       = size_reg;
        base_next       = base_reg;
        free_next       = free_reg;
        clr_ptr_next    = clr_ptr_reg;
        chk_valid_next  = 1'b0;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        frame_next      = frame_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        in_pool_next    = in_pool_reg;
        rd_addr_next    = rd_addr_reg;
        lim_next        = lim_reg;
        chk_idx_next    = chk_idx_reg;
        first_next      = first_reg;
        run_next        = run_reg;
        start_next      = start_reg;
        mark_ptr_next   = mark_ptr_reg;
        mark_left_next  = mark_left_reg;
        out_status_next = out_status_reg;
        out_frame_next  = out_frame_reg;
        out_free_next   = out_free_reg;

        if (base_wr)
        begin
            base_next = cfg_data;
        end

        if (pool_wr)
        begin
            size_next    = cfg_size;
            free_next    = COUNT_W'(cfg_size);
            clr_ptr_next = '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_ptr_next = clr_ptr_reg + 1'b1;
            end
            if (cmd.scan && hit)
            begin
                free_next = free_reg - count_reg;
            end
            if (walk_free)
            begin
                free_next = free_reg + 1'b1;
            end
        end

        if (cmd.load)
        begin
            op_next    = command;
            frame_next = frame_number;
            count_next = count;
        end

        if (cmd.decode)
        begin
            idx_next     = LEN_W'(diff[FRAME_W-1:0]);
            in_pool_next = in_pool_d;
        end

        if (cmd.start)
        begin
            rd_addr_next = (op_reg == CMD_ALLOC) ? '0 : idx_reg;
            lim_next     = (op_reg == CMD_RESERVE) ? LEN_W'(res_end) : size_reg;
            first_next   = 1'b1;
            run_next     = '0;
        end

        if (cmd.scan)
        begin
            chk_valid_next = issue_valid;
            chk_idx_next   = rd_addr_reg[IDX_W-1:0];
            if (issue_valid)
            begin
                rd_addr_next = rd_addr_reg + 1'b1;
            end
            if (chk_valid_reg)
            begin
                first_next = 1'b0;
                if (is_free)
                begin
                    run_next   = run_reg + 1'b1;
                    start_next = start_eff;
                end
                else
                begin
                    run_next = '0;
                end
            end
            if (hit)
            begin
                mark_ptr_next  = start_eff;
                mark_left_next = count_reg;
            end
        end

        if (cmd.mark)
        begin
            mark_ptr_next  = mark_ptr_reg + 1'b1;
            mark_left_next = mark_left_reg - 1'b1;
        end

        if (cmd.finish)
        begin
            out_valid_next  = 1'b1;
            out_status_next = cmd.status;
            out_free_next   = free_reg;
            if (cmd.status != ST_OK)
            begin
                out_frame_next = '0;
            end
            else if (op_reg == CMD_ALLOC)
            begin
                out_frame_next = base_reg + FRAME_W'(start_reg);
            end
            else
            begin
                out_frame_next = frame_reg;
            end
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= LEN_W'(SIZE_RST);
            base_reg      <= '0;
            free_reg      <= COUNT_W'(SIZE_RST);
            clr_ptr_reg   <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            size_reg      <= size_next;
            base_reg      <= base_next;
            free_reg      <= free_next;
            clr_ptr_reg   <= clr_ptr_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        frame_reg      <= frame_next;
        count_reg      <= count_next;
        idx_reg        <= idx_next;
        in_pool_reg    <= in_pool_next;
        rd_addr_reg    <= rd_addr_next;
        lim_reg        <= lim_next;
        chk_idx_reg    <= chk_idx_next;
        first_reg      <= first_next;
        run_reg        <= run_next;
        start_reg      <= start_next;
        mark_ptr_reg   <= mark_ptr_next;
        mark_left_reg  <= mark_left_next;
        out_status_reg <= out_status_next;
        out_frame_reg  <= out_frame_next;
        out_free_reg   <= out_free_next;
    end

    always_comb
    begin
        stat            = '0;
        stat.pool_wr    = pool_wr;
        stat.clr_last   = clr_ptr_reg == IDX_W'(NUM_FRAMES - 1);
        stat.pre_ok     = pre_ok;
        stat.is_release = is_release;
        stat.hit        = hit;
        stat.fail       = fail;
        stat.scan_end   = scan_end;
        stat.walk_stop  = walk_stop;
        stat.mark_last  = mark_left_reg == COUNT_W'(1);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_frame = out_frame_reg;
    assign free_frames  = out_free_reg;

    // free count tracks the map, so it never exceeds the pool
    a_free_le_size: assert property (@(posedge clk) disable iff (!rst_n)
        LEN_W'(free_reg) <= size_reg)
        else $error("free count above pool size");

    a_chk_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (LEN_W'(chk_idx_reg) < lim_reg))
        else $error("checked frame beyond scan limit");

    a_mark_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark |-> (LEN_W'(mark_ptr_reg) < size_reg))
        else $error("mark write outside pool");

endmodule

// ===== rtl/cfa_ctrl.sv =====
// Sequencing controller of the frame allocator: clear pass, decode, scan, walk, mark, result.
// Depends on cfa_pkg.
module cfa_ctrl
    import cfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    status_t     status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        s_ready     = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.pre_ok)
                begin
                    cmd.start  = 1'b1;
                    state_next = stat.is_release ? S_WALK : S_SCAN;
                end
                else
                begin
                    status_next = ST_RANGE;
                    state_next  = S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                priority if (stat.hit)
                begin
                    status_next = ST_OK;
                    state_next  = S_MARK;
                end
                else if (stat.fail)
                begin
                    status_next = ST_BAD_STATE;
                    state_next  = S_DONE;
                end
                else if (stat.scan_end)
                begin
                    status_next = ST_NO_FIT;
                    state_next  = S_DONE;
                end
            end
            S_WALK:
            begin
                cmd.scan = 1'b1;
                cmd.walk = 1'b1;
                priority if (stat.fail)
                begin
                    status_next = ST_BAD_STATE;
                    state_next  = S_DONE;
                end
                else if (stat.walk_stop || stat.scan_end)
                begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
            end
            S_MARK:
            begin
                cmd.mark = 1'b1;
                if (stat.mark_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase

        // a pool size write restarts the clearing pass
        if (stat.pool_wr)
        begin
            state_next = S_CLEAR;
        end
    end

    a_pool_wr_clears: assert property (@(posedge clk) disable iff (!rst_n)
        stat.pool_wr |=> (state_reg == S_CLEAR))
        else $error("pool size write did not start a clear pass");

    a_hit_xor_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !(stat.hit && stat.fail))
        else $error("scan reports hit and failure together");

    a_mark_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_MARK) |-> $past(stat.hit))
        else $error("mark entered without a scan hit");

endmodule

// ===== rtl/contiguous_frame_allocator_unit.sv =====
// Allocate scans the pool from its start, reserve checks the requested run, release walks
// the run from its head; a failed range check goes straight to the result.
// One command is in flight at a time, one frame state per cycle; the result sits in a register.
// Reset and every pool_size write run a clearing pass over all NUM_FRAMES map entries, items held off.
// Depends on cfa_pkg, cfa_ctrl, cfa_datapath and cfa_ram.
module contiguous_frame_allocator_unit
    import cfa_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // command[1:0], frame_number[21:2], count[36:22]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // status[1:0], result_frame[21:2], free_frames[36:22]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FRAME_W-1:0]   cfg_data
);

    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  result_frame;
    logic [COUNT_W-1:0]  free_frames;

    assign cfg_ready = 1'b1;

    cfa_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cfa_datapath #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .command      (s_tdata[CMD_W-1:0]),
        .frame_number (s_tdata[CMD_W +: FRAME_W]),
        .count        (s_tdata[CMD_W + FRAME_W +: COUNT_W]),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .status       (status),
        .result_frame (result_frame),
        .free_frames  (free_frames)
    );

    assign m_tdata = {{OUT_PAD_W{1'b0}}, free_frames, result_frame, status};

endmodule

// ===== tb/contiguous_frame_allocator_unit_tb.sv =====
// Self-checking testbench for contiguous_frame_allocator_unit: directed and random commands
// are checked against a frame-map predictor held in a small scoreboard class.
// Depends on cfa_pkg and the allocator RTL.
module contiguous_frame_allocator_unit_tb
    import cfa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct {
        status_t              status;
        logic [FRAME_W-1:0]   frame;
        logic [COUNT_W-1:0]   free_frames;
    } alloc_result_t;

    class frame_pool_scoreboard;
        logic [FSTATE_W-1:0] fstate [NUM_FRAMES_DEF];
        int unsigned         free_cnt;
        int unsigned         base_frame;
        int unsigned         pool_size_reg;
        alloc_result_t       expected_q [$];
        int unsigned         mismatches;

        function new();
            base_frame    = 0;
            pool_size_reg = POOL_SIZE_RST;
            mismatches    = 0;
            clear_map();
        endfunction

        function int unsigned eff_size();
            return (pool_size_reg > NUM_FRAMES_DEF) ? NUM_FRAMES_DEF : pool_size_reg;
        endfunction

        function void clear_map();
            foreach (fstate[i])
                fstate[i] = FS_FREE;
            free_cnt = eff_size();
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [FRAME_W-1:0] data);
            if (index == CFG_BASE_FRAME)
                base_frame = data;
            else
            begin
                pool_size_reg = data[COUNT_W-1:0];
                clear_map();
            end
        endfunction

        function bit to_slot(logic [FRAME_W-1:0] frame, output int unsigned idx);
            if (frame < base_frame || frame - base_frame >= eff_size())
                return 0;
            idx = frame - base_frame;
            return 1;
        endfunction

        function void mark_run(int unsigned head, int unsigned n);
            fstate[head] = FS_HEAD;
            for (int unsigned i = 1; i < n; i++)
                fstate[head + i] = FS_USED;
            free_cnt -= n;
        endfunction

        // random head slot of the current map, for well-formed releases
        function bit random_head(output int unsigned idx);
            int unsigned heads [$];
            for (int unsigned i = 0; i < eff_size(); i++)
                if (fstate[i] == FS_HEAD)
                    heads.push_back(i);
            if (heads.size() == 0)
                return 0;
            idx = heads[$urandom_range(0, heads.size() - 1)];
            return 1;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [FRAME_W-1:0] frame,
                                   logic [COUNT_W-1:0] cnt);
            int unsigned   size;
            int unsigned   idx;
            int unsigned   run;
            int unsigned   start;
            int unsigned   i;
            bit            found;
            alloc_result_t want;
            size  = eff_size();
            want.status = ST_RANGE;
            want.frame  = '0;
            case (cmd)
                CMD_ALLOC:
                begin
                    if (cnt != 0 && cnt <= size)
                    begin
                        want.status = ST_NO_FIT;
                        run   = 0;
                        start = 0;
                        found = 0;
                        for (i = 0; i < size && !found; i++)
                        begin
                            if (fstate[i] == FS_FREE)
                            begin
                                if (run == 0)
                                    start = i;
                                run++;
                                if (run == cnt)
                                    found = 1;
                            end
                            else
                                run = 0;
                        end
                        if (found)
                        begin
                            mark_run(start, cnt);
                            want.status = ST_OK;
                            want.frame  = FRAME_W'(base_frame + start);
                        end
                    end
                end
                CMD_RELEASE:
                begin
                    if (to_slot(frame, idx))
                    begin
                        if (fstate[idx] != FS_HEAD)
                            want.status = ST_BAD_STATE;
                        else
                        begin
                            fstate[idx] = FS_FREE;
                            free_cnt++;
                            // walk stops at a free frame, the next head or the pool end
                            for (i = idx + 1; i < size && fstate[i] == FS_USED; i++)
                            begin
                                fstate[i] = FS_FREE;
                                free_cnt++;
                            end
                            want.status = ST_OK;
                            want.frame  = frame;
                        end
                    end
                end
                CMD_RESERVE:
                begin
                    if (cnt != 0 && to_slot(frame, idx) && idx + cnt <= size)
                    begin
                        found = 0;
                        for (i = 0; i < cnt; i++)
                            if (fstate[idx + i] != FS_FREE)
                                found = 1;
                        if (found)
                            want.status = ST_BAD_STATE;
                        else
                        begin
                            mark_run(idx, cnt);
                            want.status = ST_OK;
                            want.frame  = frame;
                        end
                    end
                end
                default:
                    ;
            endcase
            want.free_frames = COUNT_W'(free_cnt);
            expected_q.push_back(want);
        endfunction

        function void check_result(logic [TDATA_W-1:0] word);
            alloc_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result transfer with no command outstanding: %h", word);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (word[1:0] != want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, word[1:0]);
                mismatches++;
            end
            if (word[21:2] != want.frame)
            begin
                $error("result_frame: expected %h, actual %h", want.frame, word[21:2]);
                mismatches++;
            end
            if (word[36:22] != want.free_frames)
            begin
                $error("free_frames: expected %0d, actual %0d", want.free_frames, word[36:22]);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;    // command[1:0], frame_number[21:2], count[36:22]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;    // status[1:0], result_frame[21:2], free_frames[36:22]
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FRAME_W-1:0]   cfg_data;

    frame_pool_scoreboard sb;
    bit                   tvalid_up;
    int unsigned          burst_left;

    contiguous_frame_allocator_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sender keeps tvalid high across a burst; a gap ends the burst
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [FRAME_W-1:0] frame,
                             input logic [COUNT_W-1:0] cnt);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, cnt, frame, cmd};
        tvalid_up = 1'b1;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        sb.note_command(cmd, frame, cnt);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                tvalid_up = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain_results();
        if (tvalid_up)
        begin
            s_tvalid <= 1'b0;
            tvalid_up = 1'b0;
        end
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // both registers per call; the pool_size write clears the map
    task automatic configure(input logic [FRAME_W-1:0] base_val,
                             input logic [FRAME_W-1:0] size_val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_BASE_FRAME;
        cfg_data  <= base_val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        sb.write_reg(CFG_BASE_FRAME, base_val);
        cfg_index <= CFG_POOL_SIZE;
        cfg_data  <= size_val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        sb.write_reg(CFG_POOL_SIZE, size_val);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_items(input int n, input int unsigned max_cnt);
        int unsigned      sel;
        int unsigned      size;
        int unsigned      idx;
        int unsigned      cnt;
        logic [CMD_W-1:0] cmd;
        logic [FRAME_W-1:0] frame;
        for (int k = 0; k < n; k++)
        begin
            size  = sb.eff_size();
            sel   = $urandom_range(0, 99);
            cnt   = $urandom_range(1, max_cnt);
            idx   = $urandom_range(0, size);
            cmd   = CMD_ALLOC;
            frame = FRAME_W'($urandom);
            if (sel < 40)
            begin
                if (sel < 3)
                    cnt = size + (sel == 2);
            end
            else if (sel < 70)
            begin
                cmd = CMD_RELEASE;
                if (sel < 64)
                    void'(sb.random_head(idx));
                frame = FRAME_W'(sb.base_frame + idx);
            end
            else if (sel < 88)
            begin
                cmd   = CMD_RESERVE;
                frame = FRAME_W'(sb.base_frame + idx);
            end
            else
            begin
                cmd = CMD_W'($urandom_range(0, 3));
                cnt = $urandom_range(0, 32767);
            end
            send_item(cmd, frame, COUNT_W'(cnt));
            if ($urandom_range(0, 14) == 0)
                drain_results();
        end
    endtask

    initial
    begin : stimulus
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_BASE_FRAME;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        tvalid_up  = 1'b0;
        burst_left = 0;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // full pool at base 0
        send_item(CMD_ALLOC,   20'h00000, 15'd16384);
        send_item(CMD_ALLOC,   20'h00000, 15'd1);       // no fit
        send_item(CMD_RESERVE, 20'h00005, 15'd1);       // overlaps
        send_item(CMD_RELEASE, 20'h00001, 15'd0);       // follower, not head
        send_item(CMD_RELEASE, 20'h00000, 15'd0);       // walk to pool end
        send_item(CMD_RESERVE, 20'h03FFF, 15'd1);
        send_item(CMD_RESERVE, 20'h03FFF, 15'd2);       // runs off the pool
        send_item(CMD_RELEASE, 20'h04000, 15'd0);
        send_item(CMD_ALLOC,   20'hFFFFF, 15'd0);
        send_item(CMD_ALLOC,   20'h00000, 15'h7FFF);
        send_item(CMD_RESERVE, 20'hFFFFF, 15'd0);
        send_item(CMD_UNUSED,  20'hFFFFF, 15'h7FFF);
        send_item(CMD_ALLOC,   20'h00000, 15'd3);
        send_item(CMD_RELEASE, 20'h03FFF, 15'd0);

        // pool straddling the top of the frame space
        configure(20'hFFFE0, 20'd40);
        send_item(CMD_ALLOC,   20'h00000, 15'd40);
        send_item(CMD_RELEASE, 20'hFFFE0, 15'd0);
        send_item(CMD_RESERVE, 20'hFFFE0, 15'd2);
        send_item(CMD_RESERVE, 20'hFFFE2, 15'd2);
        send_item(CMD_RELEASE, 20'hFFFE0, 15'd0);       // stops at next head
        send_item(CMD_ALLOC,   20'h00000, 15'd31);
        send_item(CMD_ALLOC,   20'h00000, 15'd5);       // head number wraps
        random_items(30, 12);

        // empty pool
        configure(20'h00000, 20'd0);
        send_item(CMD_ALLOC,   20'h00000, 15'd1);
        send_item(CMD_RELEASE, 20'h00000, 15'd0);
        send_item(CMD_RESERVE, 20'h00000, 15'd1);
        random_items(5, 4);

        // oversized pool_size clamps to the full map
        configure(20'h5A5A5, 20'hFFFFF);
        random_items(8, 24);
        drain_results();
        random_items(7, 24);

        configure(20'hFFFFF, 20'd1);
        random_items(10, 2);

        configure(20'h3C3C3, 20'd9);
        random_items(35, 5);

        drain_results();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : result_sink
        int unsigned mode;
        int unsigned mode_left;
        m_tready <= 1'b0;
        mode      = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 2) != 0);
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // clearing passes and full scans of the map run with no transfer
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
